>>> sv/ivp_pkg.sv
// Shared types, widths, constants and the sine table for the vertex projection pipeline.
package ivp_pkg;

    localparam int ELEVATION_DEG   = 30;
    localparam int COORD_FRAC_BITS = 16;

    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;
    localparam int COORD_W = 32;
    localparam int TRIG_W  = 16;   // signed Q1.14 sine and cosine
    localparam int WORLD_W = 41;   // scaled and offset coordinate
    localparam int ROTP_W  = WORLD_W + TRIG_W;  // one rotation product
    localparam int ROT_W   = ROTP_W + 1 - 14;   // rotated coordinate
    localparam int MIX_W   = ROT_W + 1;         // sum or difference of rotated coordinates
    localparam int ELP_W   = MIX_W + TRIG_W;    // elevation product
    localparam int ISO_W   = ELP_W - 14 + 1;    // projected coordinate
    localparam int ZOOM_W  = 14;
    localparam int ZP_W    = ISO_W + ZOOM_W + 1;
    localparam int PIX_W   = ZP_W - 12 + 1;
    localparam int INT_W   = PIX_W - COORD_FRAC_BITS;
    localparam int SCR_W   = 16;
    localparam int LATENCY = 7;

    typedef enum logic [IDX_W-1:0] {
        REG_VIEW_ANGLE = 3'd0,
        REG_ZOOM       = 3'd1,
        REG_SCALE      = 3'd2,
        REG_POS_X      = 3'd3,
        REG_POS_Y      = 3'd4,
        REG_POS_Z      = 3'd5,
        REG_CENTER_X   = 3'd6,
        REG_CENTER_Y   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [ZOOM_W-1:0]  zoom_factor;
        logic        [15:0]        model_scale;
        logic signed [COORD_W-1:0] model_pos_x;
        logic signed [COORD_W-1:0] model_pos_y;
        logic signed [COORD_W-1:0] model_pos_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [TRIG_W-1:0]  view_cos;
        logic signed [TRIG_W-1:0]  view_sin;
    } cfg_t;

    // round(sin(d degrees) * 16384) for d = 0..90.
    localparam logic [14:0] SINE_ROM [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // Input is below 720, so one subtraction brings it into 0..359.
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [9:0] deg);
        logic [9:0]  d;
        logic [14:0] mag;
        logic        neg;
        d = (deg >= 10'd360) ? deg - 10'd360 : deg;
        if (d <= 10'd90)
        begin
            mag = SINE_ROM[d[6:0]];
            neg = 1'b0;
        end
        else if (d <= 10'd180)
        begin
            mag = SINE_ROM[7'(10'd180 - d)];
            neg = 1'b0;
        end
        else if (d <= 10'd270)
        begin
            mag = SINE_ROM[7'(d - 10'd180)];
            neg = 1'b1;
        end
        else
        begin
            mag = SINE_ROM[7'(10'd360 - d)];
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [8:0] deg);
        logic [9:0] d;
        d = (deg >= 9'd360) ? 10'(deg) - 10'd360 : 10'(deg);
        return sin_deg(d + 10'd90);
    endfunction

    localparam logic [8:0] ANGLE_RST = 9'd45;
    localparam logic signed [TRIG_W-1:0] ELEV_COS = cos_deg(9'(ELEVATION_DEG % 360));
    localparam logic signed [TRIG_W-1:0] ELEV_SIN = sin_deg(10'(ELEVATION_DEG % 360));

endpackage

>>> sv/ivp_cfg.sv
// Configuration registers and the sine/cosine lookup of the view angle.
module ivp_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ivp_pkg::IDX_W-1:0]      cfg_addr,
    input  logic [ivp_pkg::DATA_W-1:0]     cfg_wdata,
    output ivp_pkg::cfg_t                  cfg
);

    logic [8:0]                          angle_reg;
    logic [ivp_pkg::ZOOM_W-1:0]          zoom_reg;
    logic [15:0]                         scale_reg;
    logic signed [ivp_pkg::COORD_W-1:0]  pos_x_reg;
    logic signed [ivp_pkg::COORD_W-1:0]  pos_y_reg;
    logic signed [ivp_pkg::COORD_W-1:0]  pos_z_reg;
    logic signed [ivp_pkg::COORD_W-1:0]  center_x_reg;
    logic signed [ivp_pkg::COORD_W-1:0]  center_y_reg;
    logic signed [ivp_pkg::TRIG_W-1:0]   cos_reg;
    logic signed [ivp_pkg::TRIG_W-1:0]   sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= ivp_pkg::ANGLE_RST;
            zoom_reg     <= 14'd4096;
            scale_reg    <= 16'd256;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (ivp_pkg::reg_idx_t'(cfg_addr))
                ivp_pkg::REG_VIEW_ANGLE: angle_reg    <= cfg_wdata[8:0];
                ivp_pkg::REG_ZOOM:       zoom_reg     <= cfg_wdata[ivp_pkg::ZOOM_W-1:0];
                ivp_pkg::REG_SCALE:      scale_reg    <= cfg_wdata[15:0];
                ivp_pkg::REG_POS_X:      pos_x_reg    <= $signed(cfg_wdata);
                ivp_pkg::REG_POS_Y:      pos_y_reg    <= $signed(cfg_wdata);
                ivp_pkg::REG_POS_Z:      pos_z_reg    <= $signed(cfg_wdata);
                ivp_pkg::REG_CENTER_X:   center_x_reg <= $signed(cfg_wdata);
                ivp_pkg::REG_CENTER_Y:   center_y_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // The trig values are registered from the angle; the rotation stage
    // reads them in the cycle after a transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= ivp_pkg::cos_deg(ivp_pkg::ANGLE_RST);
            sin_reg <= ivp_pkg::sin_deg(10'(ivp_pkg::ANGLE_RST));
        end
        else
        begin
            cos_reg <= ivp_pkg::cos_deg(angle_reg);
            sin_reg <= ivp_pkg::sin_deg(10'(angle_reg));
        end
    end

    always_comb
    begin
        cfg.zoom_factor = zoom_reg;
        cfg.model_scale = scale_reg;
        cfg.model_pos_x = pos_x_reg;
        cfg.model_pos_y = pos_y_reg;
        cfg.model_pos_z = pos_z_reg;
        cfg.center_x    = center_x_reg;
        cfg.center_y    = center_y_reg;
        cfg.view_cos    = cos_reg;
        cfg.view_sin    = sin_reg;
    end

endmodule

>>> sv/ivp_world.sv
// Stage 1: model scale and model position offset for all three axes.
module ivp_world
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_x,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_y,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_z,
    input  ivp_pkg::cfg_t                       cfg,
    output logic                                w_vld,
    output logic signed [ivp_pkg::WORLD_W-1:0]  w_x,
    output logic signed [ivp_pkg::WORLD_W-1:0]  w_y,
    output logic signed [ivp_pkg::WORLD_W-1:0]  w_z
);

    localparam int SP_W = ivp_pkg::COORD_W + 17;

    logic                               vld_reg;
    logic signed [ivp_pkg::WORLD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [ivp_pkg::WORLD_W-1:0] wx_next, wy_next, wz_next;
    logic signed [SP_W-1:0]             px, py, pz;
    logic signed [16:0]                 scale_s;

    always_comb
    begin
        scale_s = $signed({1'b0, cfg.model_scale});
        px = SP_W'(model_x) * SP_W'(scale_s);
        py = SP_W'(model_y) * SP_W'(scale_s);
        pz = SP_W'(model_z) * SP_W'(scale_s);
        wx_next = ivp_pkg::WORLD_W'(px >>> 8) + ivp_pkg::WORLD_W'($signed(cfg.model_pos_x));
        wy_next = ivp_pkg::WORLD_W'(py >>> 8) + ivp_pkg::WORLD_W'($signed(cfg.model_pos_y));
        wz_next = ivp_pkg::WORLD_W'(pz >>> 8) + ivp_pkg::WORLD_W'($signed(cfg.model_pos_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            wz_reg <= wz_next;
        end
    end

    assign w_vld = vld_reg;
    assign w_x   = wx_reg;
    assign w_y   = wy_reg;
    assign w_z   = wz_reg;

endmodule

>>> sv/ivp_rotate.sv
// Stages 2 and 3: rotation of x and z about the vertical axis.
module ivp_rotate
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                w_vld,
    input  logic signed [ivp_pkg::WORLD_W-1:0]  w_x,
    input  logic signed [ivp_pkg::WORLD_W-1:0]  w_y,
    input  logic signed [ivp_pkg::WORLD_W-1:0]  w_z,
    input  ivp_pkg::cfg_t                       cfg,
    output logic                                r_vld,
    output logic signed [ivp_pkg::MIX_W-1:0]    r_diff,
    output logic signed [ivp_pkg::MIX_W-1:0]    r_sum,
    output logic signed [ivp_pkg::WORLD_W-1:0]  r_wy
);

    localparam int P_W = ivp_pkg::ROTP_W;

    logic                               vld2_reg, vld3_reg;
    logic signed [P_W-1:0]              xc_reg, xs_reg, zc_reg, zs_reg;
    logic signed [ivp_pkg::WORLD_W-1:0] wy2_reg, wy3_reg;
    logic signed [ivp_pkg::MIX_W-1:0]   diff_reg, sum_reg;
    logic signed [ivp_pkg::MIX_W-1:0]   diff_next, sum_next;
    logic signed [P_W:0]                acc_x, acc_z;
    logic signed [ivp_pkg::ROT_W-1:0]   rx, rz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= w_vld;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_vld)
        begin
            xc_reg  <= P_W'(w_x) * P_W'(cfg.view_cos);
            xs_reg  <= P_W'(w_x) * P_W'(cfg.view_sin);
            zc_reg  <= P_W'(w_z) * P_W'(cfg.view_cos);
            zs_reg  <= P_W'(w_z) * P_W'(cfg.view_sin);
            wy2_reg <= w_y;
        end
    end

    // Arithmetic shift of a signed sum is the floor division by 2^14.
    always_comb
    begin
        acc_x = (P_W+1)'(xc_reg) - (P_W+1)'(zs_reg);
        acc_z = (P_W+1)'(xs_reg) + (P_W+1)'(zc_reg);
        rx = ivp_pkg::ROT_W'(acc_x >>> 14);
        rz = ivp_pkg::ROT_W'(acc_z >>> 14);
        diff_next = ivp_pkg::MIX_W'(rx) - ivp_pkg::MIX_W'(rz);
        sum_next  = ivp_pkg::MIX_W'(rx) + ivp_pkg::MIX_W'(rz);
    end

    always_ff @(posedge clk)
    begin
        if (vld2_reg)
        begin
            diff_reg <= diff_next;
            sum_reg  <= sum_next;
            wy3_reg  <= wy2_reg;
        end
    end

    assign r_vld  = vld3_reg;
    assign r_diff = diff_reg;
    assign r_sum  = sum_reg;
    assign r_wy   = wy3_reg;

endmodule

>>> sv/ivp_project.sv
// Stages 4 to 7: isometric projection, zoom, centering, truncation and saturation.
module ivp_project
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                r_vld,
    input  logic signed [ivp_pkg::MIX_W-1:0]    r_diff,
    input  logic signed [ivp_pkg::MIX_W-1:0]    r_sum,
    input  logic signed [ivp_pkg::WORLD_W-1:0]  r_wy,
    input  ivp_pkg::cfg_t                       cfg,
    output logic                                done,
    output logic signed [ivp_pkg::SCR_W-1:0]    screen_x,
    output logic signed [ivp_pkg::SCR_W-1:0]    screen_y,
    output logic                                clipped
);

    localparam int ISO_W = ivp_pkg::ISO_W;
    localparam int ELP_W = ivp_pkg::ELP_W;
    localparam int ZP_W  = ivp_pkg::ZP_W;
    localparam int PIX_W = ivp_pkg::PIX_W;
    localparam int INT_W = ivp_pkg::INT_W;
    localparam int FB    = ivp_pkg::COORD_FRAC_BITS;
    localparam int SCR_W = ivp_pkg::SCR_W;
    localparam logic signed [INT_W-1:0] SAT_MAX = INT_W'((1 << (SCR_W - 1)) - 1);
    localparam logic signed [INT_W-1:0] SAT_MIN = -INT_W'(1 << (SCR_W - 1));

    logic                      vld4_reg, vld5_reg, vld6_reg, done_reg;
    logic signed [ISO_W-1:0]   isox_reg, isoy_reg;
    logic signed [ISO_W-1:0]   isox_next, isoy_next;
    logic signed [ELP_W-1:0]   dm, sm;
    logic signed [ZP_W-1:0]    zx_reg, zy_reg;
    logic signed [PIX_W-1:0]   px_reg, py_reg;
    logic signed [PIX_W-1:0]   px_next, py_next;
    logic signed [PIX_W-1:0]   bx, by;
    logic signed [INT_W-1:0]   qx, qy;
    logic signed [SCR_W-1:0]   sx_reg, sy_reg, sx_next, sy_next;
    logic                      clip_reg, clip_next;
    logic                      hit_x, hit_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld4_reg <= r_vld;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            done_reg <= vld6_reg;
        end
    end

    // Stage 4: fixed-elevation projection.
    always_comb
    begin
        dm = ELP_W'(r_diff) * ELP_W'(ivp_pkg::ELEV_COS);
        sm = ELP_W'(r_sum) * ELP_W'(ivp_pkg::ELEV_SIN);
        isox_next = ISO_W'(dm >>> 14);
        isoy_next = ISO_W'(r_wy) + ISO_W'(sm >>> 14);
    end

    always_ff @(posedge clk)
    begin
        if (r_vld)
        begin
            isox_reg <= isox_next;
            isoy_reg <= isoy_next;
        end
    end

    // Stage 5: zoom.
    always_ff @(posedge clk)
    begin
        if (vld4_reg)
        begin
            zx_reg <= ZP_W'(isox_reg) * ZP_W'($signed({1'b0, cfg.zoom_factor}));
            zy_reg <= ZP_W'(isoy_reg) * ZP_W'($signed({1'b0, cfg.zoom_factor}));
        end
    end

    // Stage 6: back to coordinate format and screen centering.
    always_comb
    begin
        px_next = PIX_W'(zx_reg >>> 12) + PIX_W'($signed(cfg.center_x));
        py_next = PIX_W'(zy_reg >>> 12) + PIX_W'($signed(cfg.center_y));
    end

    always_ff @(posedge clk)
    begin
        if (vld5_reg)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // Stage 7: a negative value gets a bias of 2^FB - 1 so that the
    // arithmetic shift truncates toward zero, then saturation.
    always_comb
    begin
        bx = px_reg + $signed({{(PIX_W-FB){1'b0}}, {FB{px_reg[PIX_W-1]}}});
        by = py_reg + $signed({{(PIX_W-FB){1'b0}}, {FB{py_reg[PIX_W-1]}}});
        qx = INT_W'(bx >>> FB);
        qy = INT_W'(by >>> FB);
        hit_x = (qx > SAT_MAX) || (qx < SAT_MIN);
        hit_y = (qy > SAT_MAX) || (qy < SAT_MIN);
        if (qx > SAT_MAX)
            sx_next = SAT_MAX[SCR_W-1:0];
        else if (qx < SAT_MIN)
            sx_next = SAT_MIN[SCR_W-1:0];
        else
            sx_next = qx[SCR_W-1:0];
        if (qy > SAT_MAX)
            sy_next = SAT_MAX[SCR_W-1:0];
        else if (qy < SAT_MIN)
            sy_next = SAT_MIN[SCR_W-1:0];
        else
            sy_next = qy[SCR_W-1:0];
        clip_next = hit_x || hit_y;
    end

    always_ff @(posedge clk)
    begin
        if (vld6_reg)
        begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            clip_reg <= clip_next;
        end
    end

    assign done     = done_reg;
    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
    assign clipped  = clip_reg;

endmodule

>>> sv/isometric_vertex_projection.sv
// Top level of the isometric vertex projection pipeline.
//
//  channel   handshake          payload
//  vertex    start, busy        model_x, model_y, model_z
//  result    done (strobe)      screen_x, screen_y, clipped
//  config    cfg_we             cfg_addr, cfg_wdata
//
// One vertex is taken every clock; busy stays low. Each result passes
// through the seven register stages:
// scale and offset, rotation products, rotation sums, elevation, zoom,
// centering, truncation and saturation. Reset clears the valid bits and
// restores the register defaults. The receiver cannot stall, so the
// pipeline never holds.
module isometric_vertex_projection
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_x,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_y,
    input  logic signed [ivp_pkg::COORD_W-1:0]  model_z,
    output logic                                done,
    output logic signed [ivp_pkg::SCR_W-1:0]    screen_x,
    output logic signed [ivp_pkg::SCR_W-1:0]    screen_y,
    output logic                                clipped,
    input  logic                                cfg_we,
    input  logic [ivp_pkg::IDX_W-1:0]           cfg_addr,
    input  logic [ivp_pkg::DATA_W-1:0]          cfg_wdata
);

    ivp_pkg::cfg_t                      cfg;
    logic                               w_vld, r_vld;
    logic signed [ivp_pkg::WORLD_W-1:0] w_x, w_y, w_z, r_wy;
    logic signed [ivp_pkg::MIX_W-1:0]   r_diff, r_sum;

    assign busy = 1'b0;

    ivp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ivp_world u_world
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .model_x (model_x),
        .model_y (model_y),
        .model_z (model_z),
        .cfg     (cfg),
        .w_vld   (w_vld),
        .w_x     (w_x),
        .w_y     (w_y),
        .w_z     (w_z)
    );

    ivp_rotate u_rotate
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .w_vld  (w_vld),
        .w_x    (w_x),
        .w_y    (w_y),
        .w_z    (w_z),
        .cfg    (cfg),
        .r_vld  (r_vld),
        .r_diff (r_diff),
        .r_sum  (r_sum),
        .r_wy   (r_wy)
    );

    ivp_project u_project
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .r_vld    (r_vld),
        .r_diff   (r_diff),
        .r_sum    (r_sum),
        .r_wy     (r_wy),
        .cfg      (cfg),
        .done     (done),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .clipped  (clipped)
    );

    // Every accepted transaction yields a result after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("accepted vertex produced no result after the pipeline latency");

    // No result appears without a transaction taken the same latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ivp_pkg::LATENCY))
        else $error("result strobe without a matching accepted vertex");

    // A clipped result carries at least one coordinate at a saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |->
            (screen_x == 16'sh7FFF || screen_x == -16'sh8000 ||
             screen_y == 16'sh7FFF || screen_y == -16'sh8000))
        else $error("clipped flag set with both coordinates inside range");

endmodule

>>> verif/isometric_vertex_projection_tb.sv
// Self-checking testbench for the isometric vertex projection pipeline.
module isometric_vertex_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEM_TARGET = 550;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int          MAX_PRINTS  = 40;

    typedef struct packed {
        logic signed [ivp_pkg::COORD_W-1:0] x;
        logic signed [ivp_pkg::COORD_W-1:0] y;
        logic signed [ivp_pkg::COORD_W-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic signed [ivp_pkg::SCR_W-1:0] sx;
        logic signed [ivp_pkg::SCR_W-1:0] sy;
        logic                             clip;
    } screen_t;

    typedef enum { PICK_LOW, PICK_HIGH, PICK_TYPICAL, PICK_WILD } pick_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic signed [ivp_pkg::COORD_W-1:0] model_x = '0;
    logic signed [ivp_pkg::COORD_W-1:0] model_y = '0;
    logic signed [ivp_pkg::COORD_W-1:0] model_z = '0;
    logic                               done;
    logic signed [ivp_pkg::SCR_W-1:0]   screen_x;
    logic signed [ivp_pkg::SCR_W-1:0]   screen_y;
    logic                               clipped;
    logic                               cfg_we = 1'b0;
    logic [ivp_pkg::IDX_W-1:0]          cfg_addr = '0;
    logic [ivp_pkg::DATA_W-1:0]         cfg_wdata = '0;

    // Shadow copy of the register file, masked to register widths.
    logic [8:0]                         view_angle = 9'd45;
    logic [ivp_pkg::ZOOM_W-1:0]         zoom = 14'd4096;
    logic [15:0]                        scale = 16'd256;
    logic signed [ivp_pkg::COORD_W-1:0] pos_x = '0;
    logic signed [ivp_pkg::COORD_W-1:0] pos_y = '0;
    logic signed [ivp_pkg::COORD_W-1:0] pos_z = '0;
    logic signed [ivp_pkg::COORD_W-1:0] ctr_x = '0;
    logic signed [ivp_pkg::COORD_W-1:0] ctr_y = '0;

    int sin_q14 [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    vtx_t        vertex_q [$];
    screen_t     proj_q [$];
    screen_t     want;
    vtx_t        nxt;
    logic        vtx_taken = 1'b0;
    int          gap_pct = 9;
    int          n_queued = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_clipped = 0;
    int          n_settings = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;

    isometric_vertex_projection uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .model_x   (model_x),
        .model_y   (model_y),
        .model_z   (model_z),
        .done      (done),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .clipped   (clipped),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Quarter-wave table folded out to a full turn, Q1.14.
    function automatic longint trig_sin(input int unsigned deg);
        int unsigned d;
        d = deg % 360;
        if (d <= 90)
            return sin_q14[d];
        else if (d <= 180)
            return sin_q14[180 - d];
        else if (d <= 270)
            return -sin_q14[d - 180];
        else
            return -sin_q14[360 - d];
    endfunction

    // All intermediates fit comfortably in 64 bits, so >>> gives exact floors.
    function automatic screen_t project_vertex(input vtx_t v);
        longint  wx, wy, wz, ca, sa, rx, rz, ce, se, ix, iy, px, py, tx, ty;
        screen_t r;
        wx = ((longint'($signed(v.x)) * longint'(scale)) >>> 8) + longint'($signed(pos_x));
        wy = ((longint'($signed(v.y)) * longint'(scale)) >>> 8) + longint'($signed(pos_y));
        wz = ((longint'($signed(v.z)) * longint'(scale)) >>> 8) + longint'($signed(pos_z));
        ca = trig_sin(int'(view_angle) + 90);
        sa = trig_sin(int'(view_angle));
        rx = (wx * ca - wz * sa) >>> 14;
        rz = (wx * sa + wz * ca) >>> 14;
        ce = trig_sin(ivp_pkg::ELEVATION_DEG + 90);
        se = trig_sin(ivp_pkg::ELEVATION_DEG);
        ix = ((rx - rz) * ce) >>> 14;
        iy = wy + (((rx + rz) * se) >>> 14);
        px = ((ix * longint'(zoom)) >>> 12) + longint'($signed(ctr_x));
        py = ((iy * longint'(zoom)) >>> 12) + longint'($signed(ctr_y));
        tx = (px < 0) ? -((-px) >>> ivp_pkg::COORD_FRAC_BITS)
                      : (px >>> ivp_pkg::COORD_FRAC_BITS);
        ty = (py < 0) ? -((-py) >>> ivp_pkg::COORD_FRAC_BITS)
                      : (py >>> ivp_pkg::COORD_FRAC_BITS);
        r.clip = (tx > 32767) || (tx < -32768) || (ty > 32767) || (ty < -32768);
        r.sx = (tx > 32767) ? 16'sh7fff : (tx < -32768) ? 16'sh8000 : 16'(tx);
        r.sy = (ty > 32767) ? 16'sh7fff : (ty < -32768) ? 16'sh8000 : 16'(ty);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom_range(32'd262144000) - 32'd131072000;
        else if (roll < 85)
            return $urandom;
        case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            default: return 32'h00010000;
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(input ivp_pkg::reg_idx_t idx, input pick_t how);
        logic [31:0] lo, hi, typ, wild;
        case (idx)
            ivp_pkg::REG_VIEW_ANGLE:
            begin
                lo = 32'd0;
                hi = 32'd359;
                typ = $urandom_range(359);
                // Angles 360..511 wrap; bits above the register are dropped.
                wild = ($urandom & 32'hfffffe00) | $urandom_range(360, 511);
            end
            ivp_pkg::REG_ZOOM:
            begin
                lo = 32'd2048;
                hi = 32'd12288;
                typ = $urandom_range(2048, 12288);
                case ($urandom_range(2))
                    0: wild = $urandom & 32'hffffc000;
                    1: wild = $urandom | 32'h00003fff;
                    default: wild = $urandom;
                endcase
            end
            ivp_pkg::REG_SCALE:
            begin
                lo = 32'd0;
                hi = 32'd65535;
                typ = $urandom_range(64, 1024);
                wild = $urandom;
            end
            default:
            begin
                lo = 32'h80000000;
                hi = 32'h7fffffff;
                typ = $urandom_range(32'd131072000) - 32'd65536000;
                wild = $urandom;
            end
        endcase
        case (how)
            PICK_LOW: return lo;
            PICK_HIGH: return hi;
            PICK_TYPICAL: return typ;
            default: return wild;
        endcase
    endfunction

    task automatic write_reg(input ivp_pkg::reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            ivp_pkg::REG_VIEW_ANGLE: view_angle = val[8:0];
            ivp_pkg::REG_ZOOM:       zoom = val[ivp_pkg::ZOOM_W-1:0];
            ivp_pkg::REG_SCALE:      scale = val[15:0];
            ivp_pkg::REG_POS_X:      pos_x = val;
            ivp_pkg::REG_POS_Y:      pos_y = val;
            ivp_pkg::REG_POS_Z:      pos_z = val;
            ivp_pkg::REG_CENTER_X:   ctr_x = val;
            ivp_pkg::REG_CENTER_Y:   ctr_y = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_addr <= ivp_pkg::IDX_W'($urandom);
        cfg_wdata <= $urandom;
    endtask

    task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
        vertex_q.push_back('{x: x, y: y, z: z});
        n_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_sent != n_queued || proj_q.size() != 0);
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Driver: holds a vertex until it is taken, otherwise puts noise on the payload.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !vtx_taken)
        begin
        end
        else if (vertex_q.size() != 0 && $urandom_range(99) >= gap_pct)
        begin
            nxt = vertex_q.pop_front();
            start <= 1'b1;
            model_x <= nxt.x;
            model_y <= nxt.y;
            model_z <= nxt.z;
        end
        else
        begin
            start <= 1'b0;
            model_x <= $urandom;
            model_y <= $urandom;
            model_z <= $urandom;
        end
    end

    // Monitor: predicts on every accepted transaction and checks every strobe.
    always @(posedge clk)
    begin
        if (!rst_n)
            vtx_taken <= 1'b0;
        else
        begin
            vtx_taken <= start && !busy;
            if (start && !busy)
            begin
                proj_q.push_back(project_vertex('{x: model_x, y: model_y, z: model_z}));
                n_sent++;
            end
            if (done)
            begin
                n_results++;
                if (proj_q.size() == 0)
                    report_mismatch($sformatf("result (%0d, %0d, clip %0b) with no vertex pending",
                                              screen_x, screen_y, clipped));
                else
                begin
                    want = proj_q.pop_front();
                    if (want.clip)
                        n_clipped++;
                    if (screen_x !== want.sx)
                        report_mismatch($sformatf("result %0d: screen_x %0d, predicted %0d",
                                                  n_results, screen_x, want.sx));
                    if (screen_y !== want.sy)
                        report_mismatch($sformatf("result %0d: screen_y %0d, predicted %0d",
                                                  n_results, screen_y, want.sy));
                    if (clipped !== want.clip)
                        report_mismatch($sformatf("result %0d: clipped %b, predicted %b",
                                                  n_results, clipped, want.clip));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, proj_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        pick_t              how;
        ivp_pkg::reg_idx_t  ri;
        int unsigned        batch;
        int                 n_random;
        n_random = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed vertices at the reset settings: 45 degrees, unit scale and zoom.
        queue_vertex(32'h00000000, 32'h00000000, 32'h00000000);
        queue_vertex(32'h00010000, 32'h00000000, 32'h00000000);
        queue_vertex(32'h00000000, 32'h00010000, 32'h00000000);
        queue_vertex(32'h00000000, 32'h00000000, 32'h00010000);
        queue_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_vertex(32'h00000000, 32'hffff8000, 32'h00000000);
        queue_vertex(32'h00000000, 32'h7fffffff, 32'h00000000);
        queue_vertex(32'h00000000, 32'h80000000, 32'h00000000);
        queue_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_vertex(32'h80000000, 32'h80000000, 32'h80000000);
        queue_vertex(32'h7fffffff, 32'h00000000, 32'h80000000);
        queue_vertex(32'h80000000, 32'h00000000, 32'h7fffffff);
        queue_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        queue_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
        queue_vertex(32'h00640000, 32'hff9c0000, 32'h00320000);
        queue_vertex(32'hfff0ffff, 32'h00008000, 32'h000f0001);
        wait_idle();

        // Each setting is written while the pipeline is empty, then a batch streams through.
        while (n_random < ITEM_TARGET)
        begin
            ri = ri.first();
            do
            begin
                if (n_settings == 0)
                    how = PICK_LOW;
                else if (n_settings == 1)
                    how = PICK_HIGH;
                else if ($urandom_range(1) != 0)
                    how = PICK_TYPICAL;
                else
                    how = pick_t'($urandom_range(3));
                write_reg(ri, cfg_value(ri, how));
                ri = ri.next();
            end
            while (ri != ri.first());
            n_settings++;
            gap_pct = (n_settings == 3) ? 0 : 9;
            batch = (n_settings == 3) ? 80 : $urandom_range(15, 50);
            repeat (batch) queue_vertex(rand_coord(), rand_coord(), rand_coord());
            n_random += batch;
            wait_idle();
        end

        repeat (2 * ivp_pkg::LATENCY) @(negedge clk);
        $display("Projected %0d vertices under %0d register settings plus reset defaults;",
                 n_sent, n_settings);
        $display("%0d of %0d results were saturated.", n_clipped, n_results);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> isometric_vertex_projection.f
sv/ivp_pkg.sv
sv/ivp_cfg.sv
sv/ivp_world.sv
sv/ivp_rotate.sv
sv/ivp_project.sv
sv/isometric_vertex_projection.sv
verif/isometric_vertex_projection_tb.sv
